FILE: hw/rtl/uartrm_pkg.sv
// Package with the types, register codes and constants of the UART register model.
`timescale 1ns / 1ps

package uartrm_pkg;

    // Kind of a request transaction.
    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_RX     = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req_kind;

    // Register offsets on the bus.
    localparam logic [2:0] REG_DATA    = 3'd0;
    localparam logic [2:0] REG_IER     = 3'd1;
    localparam logic [2:0] REG_IIR     = 3'd2;
    localparam logic [2:0] REG_LCR     = 3'd3;
    localparam logic [2:0] REG_MCR     = 3'd4;
    localparam logic [2:0] REG_LSR     = 3'd5;
    localparam logic [2:0] REG_MSR     = 3'd6;
    localparam logic [2:0] REG_SCRATCH = 3'd7;

    // Interrupt identification codes.
    localparam logic [2:0] IIR_NONE  = 3'h1;
    localparam logic [2:0] IIR_LINE  = 3'h6;
    localparam logic [2:0] IIR_RDA   = 3'h4;
    localparam logic [2:0] IIR_THRE  = 3'h2;
    localparam logic [2:0] IIR_MODEM = 3'h0;

    // Line and modem status constants.
    localparam logic [7:0] LSR_RESET    = 8'h60;
    localparam logic [7:0] LSR_ERR_MASK = 8'h1e;
    localparam logic [7:0] LSR_RD_KEEP  = 8'he1;
    localparam logic [7:0] MSR_RD_KEEP  = 8'hf0;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] reg_index;
        logic [7:0] data_in;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_line;
    } t_rsp;

endpackage

FILE: hw/rtl/uartrm_req_if.sv
// Handshake interface that carries request transactions into the UART register model.
`timescale 1ns / 1ps

interface uartrm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [2:0] reg_index;
    logic [7:0] data_in;

    modport source (output valid, output req_type, output reg_index, output data_in,
                    input ready);
    modport sink (input valid, input req_type, input reg_index, input data_in,
                  output ready);
endinterface

FILE: hw/rtl/uartrm_rsp_if.sv
// Handshake interface that carries result transactions out of the UART register model.
`timescale 1ns / 1ps

interface uartrm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_line;

    modport source (output valid, output read_data, output tx_valid, output tx_byte,
                    output irq_line, input ready);
    modport sink (input valid, input read_data, input tx_valid, input tx_byte,
                  input irq_line, output ready);
endinterface

FILE: hw/rtl/uartrm_regs.sv
// Register file of the UART: state registers and the update logic for one transaction.
`timescale 1ns / 1ps

module uartrm_regs
    import uartrm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [15:0] r_divisor,   n_divisor;
    logic [7:0]  r_rx_buf,    n_rx_buf;
    logic [3:0]  r_ier,       n_ier;
    logic [2:0]  r_iir,       n_iir;
    logic [7:0]  r_lcr,       n_lcr;
    logic [4:0]  r_mcr,       n_mcr;
    logic [7:0]  r_lsr,       n_lsr;
    logic [7:0]  r_msr,       n_msr;
    logic [7:0]  r_scratch,   n_scratch;
    logic        r_thre_pend, n_thre_pend;
    logic        r_irq,       n_irq;

    logic        w_dlab;
    logic        w_div_hit;
    logic        w_recompute;
    logic [7:0]  w_prev;
    logic [7:0]  w_now;
    logic [7:0]  w_rd;
    logic        w_txv;
    logic [7:0]  w_txb;
    logic [2:0]  w_id;

    assign w_dlab    = r_lcr[7];
    assign w_div_hit = w_dlab && (i_req.reg_index == REG_DATA || i_req.reg_index == REG_IER);

    always_comb begin
        n_divisor   = r_divisor;
        n_rx_buf    = r_rx_buf;
        n_ier       = r_ier;
        n_lcr       = r_lcr;
        n_mcr       = r_mcr;
        n_lsr       = r_lsr;
        n_msr       = r_msr;
        n_scratch   = r_scratch;
        n_thre_pend = r_thre_pend;
        w_recompute = 1'b0;
        w_rd        = 8'h00;
        w_txv       = 1'b0;
        w_txb       = 8'h00;
        w_prev      = r_msr & MSR_RD_KEEP;
        w_now       = 8'h00;

        case (t_req_kind'(i_req.req_type))
            REQ_READ: begin
                if (w_div_hit) begin
                    w_rd = (i_req.reg_index == REG_DATA) ? r_divisor[7:0] : r_divisor[15:8];
                end else begin
                    w_recompute = 1'b1;
                    case (i_req.reg_index)
                        REG_DATA: begin
                            w_rd     = r_rx_buf;
                            n_lsr[0] = 1'b0;
                        end
                        REG_IER:  w_rd = {4'h0, r_ier};
                        REG_IIR: begin
                            w_rd = {5'h00, r_iir};
                            if (r_iir == IIR_THRE) begin
                                n_thre_pend = 1'b0;
                            end
                        end
                        REG_LCR:  w_rd = r_lcr;
                        REG_MCR:  w_rd = {3'h0, r_mcr};
                        REG_LSR: begin
                            w_rd  = r_lsr;
                            n_lsr = r_lsr & LSR_RD_KEEP;
                        end
                        REG_MSR: begin
                            w_rd  = r_msr;
                            n_msr = r_msr & MSR_RD_KEEP;
                        end
                        default:  w_rd = r_scratch;
                    endcase
                end
            end
            REQ_WRITE: begin
                if (w_div_hit) begin
                    if (i_req.reg_index == REG_DATA) begin
                        n_divisor[7:0] = i_req.data_in;
                    end else begin
                        n_divisor[15:8] = i_req.data_in;
                    end
                end else begin
                    w_recompute = 1'b1;
                    case (i_req.reg_index)
                        REG_DATA: begin
                            n_thre_pend = 1'b1;
                            if (r_mcr[4]) begin
                                // Loopback: the byte returns as a received byte.
                                n_rx_buf = i_req.data_in;
                                n_lsr[1] = r_lsr[1] | r_lsr[0];
                                n_lsr[0] = 1'b1;
                            end else begin
                                w_txv = 1'b1;
                                w_txb = i_req.data_in;
                            end
                        end
                        REG_IER: begin
                            n_ier = i_req.data_in[3:0];
                            if (i_req.data_in[1] && r_lsr[5]) begin
                                n_thre_pend = 1'b1;
                            end
                        end
                        REG_LCR: n_lcr = i_req.data_in;
                        REG_MCR: begin
                            n_mcr = i_req.data_in[4:0];
                            if (i_req.data_in[4]) begin
                                w_now = {i_req.data_in[3], i_req.data_in[2],
                                         i_req.data_in[0], i_req.data_in[1], 4'h0};
                            end
                            n_msr[7:4] = w_now[7:4];
                            n_msr[0]   = w_prev[4] ^ w_now[4];
                            n_msr[1]   = w_prev[5] ^ w_now[5];
                            n_msr[2]   = w_prev[6] & ~w_now[6];
                            n_msr[3]   = w_prev[7] ^ w_now[7];
                        end
                        REG_SCRATCH: n_scratch = i_req.data_in;
                        default: ;
                    endcase
                end
            end
            REQ_RX: begin
                w_recompute = 1'b1;
                n_rx_buf    = i_req.data_in;
                n_lsr[1]    = r_lsr[1] | r_lsr[0];
                n_lsr[0]    = 1'b1;
            end
            default: ;
        endcase

        // Interrupt priority: line errors, data ready, transmitter empty, modem status.
        if (n_ier[2] && (n_lsr & LSR_ERR_MASK) != 8'h00) begin
            w_id = IIR_LINE;
        end else if (n_ier[0] && n_lsr[0]) begin
            w_id = IIR_RDA;
        end else if (n_ier[1] && n_thre_pend) begin
            w_id = IIR_THRE;
        end else if (n_ier[3] && n_msr[3:0] != 4'h0) begin
            w_id = IIR_MODEM;
        end else begin
            w_id = IIR_NONE;
        end

        n_iir = w_recompute ? w_id : r_iir;
        n_irq = w_recompute ? ~w_id[0] : r_irq;

        o_rsp.read_data = w_rd;
        o_rsp.tx_valid  = w_txv;
        o_rsp.tx_byte   = w_txb;
        o_rsp.irq_line  = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor   <= 16'h0000;
            r_rx_buf    <= 8'h00;
            r_ier       <= 4'h0;
            r_iir       <= IIR_NONE;
            r_lcr       <= 8'h00;
            r_mcr       <= 5'h00;
            r_lsr       <= LSR_RESET;
            r_msr       <= 8'h00;
            r_scratch   <= 8'h00;
            r_thre_pend <= 1'b0;
            r_irq       <= 1'b0;
        end else if (i_fire) begin
            r_divisor   <= n_divisor;
            r_rx_buf    <= n_rx_buf;
            r_ier       <= n_ier;
            r_iir       <= n_iir;
            r_lcr       <= n_lcr;
            r_mcr       <= n_mcr;
            r_lsr       <= n_lsr;
            r_msr       <= n_msr;
            r_scratch   <= n_scratch;
            r_thre_pend <= n_thre_pend;
            r_irq       <= n_irq;
        end
    end

`ifndef NO_ASSERTIONS
    // The interrupt level always agrees with the pending bit of the identification.
    a_irq_matches_iir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq == ~r_iir[0])
        else $error("irq level disagrees with interrupt identification");

    // A line status read clears all error bits.
    a_lsr_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.req_type == REQ_READ && !w_dlab && i_req.reg_index == REG_LSR)
        |=> (r_lsr & LSR_ERR_MASK) == 8'h00)
        else $error("line status errors survived a read");

    // A received byte always leaves data ready set.
    a_rx_sets_dr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.req_type == REQ_RX) |=> r_lsr[0])
        else $error("data ready not set after a received byte");
`endif

endmodule

FILE: hw/rtl/uart_register_model_top.sv
// Top level of the UART register model: input stage, register file and result stage.
// An accepted request is held in the input stage, passes through the register file into
// the result stage and is presented from there as a result.
// Throughput: one transaction per cycle; the input stage advances whenever the
// result stage is empty or is being drained in the same cycle.
// Reset: synchronous, active low; clears both stages and puts every register at its
// power-on value (line status 0x60, interrupt identification "none pending").
`timescale 1ns / 1ps

module uart_register_model_top
    import uartrm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    uartrm_req_if.sink   i_req,
    uartrm_rsp_if.source o_rsp
);

    // Input stage: holds one request transaction until the register file takes it.
    logic r_in_valid;
    t_req r_in;

    // Result stage: holds one result transaction until the consumer takes it.
    logic r_out_valid;
    t_rsp r_out;

    // The register file updates its state exactly when the input stage advances.
    logic w_adv;
    t_rsp w_rsp;

    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    uartrm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_req   (r_in),
        .o_rsp   (w_rsp)
    );

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage payloads need no reset; the valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.req_type  <= i_req.req_type;
            r_in.reg_index <= i_req.reg_index;
            r_in.data_in   <= i_req.data_in;
        end
        if (w_adv) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out.read_data;
    assign o_rsp.tx_valid  = r_out.tx_valid;
    assign o_rsp.tx_byte   = r_out.tx_byte;
    assign o_rsp.irq_line  = r_out.irq_line;

`ifndef NO_ASSERTIONS
    // A result can only appear after a request left the input stage.
    a_out_from_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv))
        else $error("result appeared without an advancing request");
`endif

endmodule

FILE: tb/uartrm_checker.sv
// Checker that predicts and compares the result transactions of the UART register model.
`timescale 1ns / 1ps

module uartrm_checker
    import uartrm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    uartrm_req_if  i_req_mon,
    uartrm_rsp_if  i_rsp_mon,
    output int     o_err_count,
    output int     o_outstanding
);

    // Shadow copy of the register file.
    logic [15:0] divisor;
    logic [7:0]  rx_hold;
    logic [3:0]  ier;
    logic [2:0]  iir;
    logic [7:0]  lcr;
    logic [4:0]  mcr;
    logic [7:0]  lsr;
    logic [7:0]  msr;
    logic [7:0]  scratch;
    logic        thre_pending;
    logic        irq;

    t_rsp rsp_pending_q[$];
    int   mismatches = 0;

    // Interrupt priority: line errors, data ready, transmitter empty, modem status.
    function automatic void refresh_iir();
        logic [2:0] id;
        id = IIR_NONE;
        if (ier[2] && (lsr & LSR_ERR_MASK) != 8'h00)
            id = IIR_LINE;
        else if (ier[0] && lsr[0])
            id = IIR_RDA;
        else if (ier[1] && thre_pending)
            id = IIR_THRE;
        else if (ier[3] && msr[3:0] != 4'h0)
            id = IIR_MODEM;
        iir = id;
        irq = ~id[0];
    endfunction

    // A new byte on top of unread data flags an overrun.
    function automatic void receive_byte(logic [7:0] b);
        if (lsr[0])
            lsr[1] = 1'b1;
        rx_hold = b;
        lsr[0]  = 1'b1;
    endfunction

    function automatic t_rsp uart_access(t_req rq);
        t_rsp       r;
        logic [7:0] prev_lines;
        logic [7:0] new_lines;
        logic       dlab;
        r    = '0;
        dlab = lcr[7];
        case (rq.req_type)
            REQ_READ: begin
                if (dlab && rq.reg_index <= REG_IER) begin
                    r.read_data = (rq.reg_index == REG_DATA) ? divisor[7:0] : divisor[15:8];
                end else begin
                    case (rq.reg_index)
                        REG_DATA: begin
                            r.read_data = rx_hold;
                            lsr[0] = 1'b0;
                        end
                        REG_IER: r.read_data = {4'b0000, ier};
                        REG_IIR: begin
                            r.read_data = {5'b00000, iir};
                            if (iir == IIR_THRE)
                                thre_pending = 1'b0;
                        end
                        REG_LCR: r.read_data = lcr;
                        REG_MCR: r.read_data = {3'b000, mcr};
                        REG_LSR: begin
                            r.read_data = lsr;
                            lsr = lsr & LSR_RD_KEEP;
                        end
                        REG_MSR: begin
                            r.read_data = msr;
                            msr = msr & MSR_RD_KEEP;
                        end
                        default: r.read_data = scratch;
                    endcase
                    refresh_iir();
                end
            end
            REQ_WRITE: begin
                if (dlab && rq.reg_index == REG_DATA) begin
                    divisor[7:0] = rq.data_in;
                end else if (dlab && rq.reg_index == REG_IER) begin
                    divisor[15:8] = rq.data_in;
                end else begin
                    case (rq.reg_index)
                        REG_DATA: begin
                            thre_pending = 1'b1;
                            if (mcr[4]) begin
                                receive_byte(rq.data_in);
                            end else begin
                                r.tx_valid = 1'b1;
                                r.tx_byte  = rq.data_in;
                            end
                        end
                        REG_IER: begin
                            ier = rq.data_in[3:0];
                            if (rq.data_in[1] && lsr[5])
                                thre_pending = 1'b1;
                        end
                        REG_LCR: lcr = rq.data_in;
                        REG_MCR: begin
                            prev_lines = msr & MSR_RD_KEEP;
                            mcr        = rq.data_in[4:0];
                            // In loopback CTS, DSR, RI and DCD follow RTS, DTR, OUT1 and OUT2.
                            new_lines  = mcr[4] ? {mcr[3], mcr[2], mcr[0], mcr[1], 4'h0} : 8'h00;
                            msr        = new_lines;
                            msr[0]     = prev_lines[4] ^ new_lines[4];
                            msr[1]     = prev_lines[5] ^ new_lines[5];
                            msr[2]     = prev_lines[6] & ~new_lines[6];
                            msr[3]     = prev_lines[7] ^ new_lines[7];
                        end
                        REG_SCRATCH: scratch = rq.data_in;
                        default: ;
                    endcase
                    refresh_iir();
                end
            end
            REQ_RX: begin
                receive_byte(rq.data_in);
                refresh_iir();
            end
            default: ;
        endcase
        r.irq_line = irq;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        t_rsp got;
        t_req rq;
        if (!i_rst_n) begin
            divisor      = '0;
            rx_hold      = '0;
            ier          = '0;
            iir          = IIR_NONE;
            lcr          = '0;
            mcr          = '0;
            lsr          = LSR_RESET;
            msr          = '0;
            scratch      = '0;
            thre_pending = 1'b0;
            irq          = 1'b0;
            rsp_pending_q.delete();
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got.read_data = i_rsp_mon.read_data;
                got.tx_valid  = i_rsp_mon.tx_valid;
                got.tx_byte   = i_rsp_mon.tx_byte;
                got.irq_line  = i_rsp_mon.irq_line;
                if (rsp_pending_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                end else begin
                    want = rsp_pending_q.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("tx_valid", {7'b0, want.tx_valid}, {7'b0, got.tx_valid});
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("irq_line", {7'b0, want.irq_line}, {7'b0, got.irq_line});
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                rq.req_type  = i_req_mon.req_type;
                rq.reg_index = i_req_mon.reg_index;
                rq.data_in   = i_req_mon.data_in;
                rsp_pending_q.push_back(uart_access(rq));
            end
        end
        o_outstanding <= rsp_pending_q.size();
        o_err_count   <= mismatches;
    end

endmodule

FILE: tb/tb_uart_register_model_top.sv
// Testbench top for the UART register model: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_uart_register_model_top
    import uartrm_pkg::*;
();

    // Number of random transactions after the directed part.
    localparam int RANDOM_ACCESSES = 600;
    // Cycles to wait after the last result, well beyond the time a result takes through both stages.
    localparam int DRAIN_CYCLES    = 20;

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   outstanding;

    // Sender burst bookkeeping: transactions left before the next gap.
    int   burst_left = 0;

    // Receiver stall pattern: the current mode and how long it lasts.
    int   rsp_mode   = 0;
    int   mode_left  = 0;

    uartrm_req_if req_if ();
    uartrm_rsp_if rsp_if ();

    uart_register_model_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    uartrm_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (req_if),
        .i_rsp_mon     (rsp_if),
        .o_err_count   (err_count),
        .o_outstanding (outstanding)
    );

    // 125 MHz clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The receiver switches between stall patterns at random intervals: always
    // ready, toggling every cycle, ready half the time, and ready rarely. The
    // always-ready mode gives stretches where results drain with no stall at all.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rsp_mode  <= $urandom_range(0, 3);
            mode_left <= $urandom_range(8, 80);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rsp_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ~rsp_if.ready;
            2:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic t_req make_access(t_req_kind kind, logic [2:0] idx, logic [7:0] data);
        t_req rq;
        rq.req_type  = kind;
        rq.reg_index = idx;
        rq.data_in   = data;
        return rq;
    endfunction

    // Random transaction. Reads, writes and line bytes dominate; the unused
    // request kind shows up now and then. Writes to line control mostly keep
    // DLAB clear so that the normal registers stay reachable most of the time.
    function automatic t_req random_access();
        t_req rq;
        int   pick;
        pick         = $urandom_range(0, 99);
        rq.reg_index = 3'($urandom_range(0, 7));
        rq.data_in   = 8'($urandom_range(0, 255));
        if (pick < 35)
            rq.req_type = REQ_READ;
        else if (pick < 72)
            rq.req_type = REQ_WRITE;
        else if (pick < 95)
            rq.req_type = REQ_RX;
        else
            rq.req_type = REQ_UNUSED;
        if (rq.req_type == REQ_WRITE && rq.reg_index == REG_LCR && $urandom_range(0, 3) != 0)
            rq.data_in[7] = 1'b0;
        return rq;
    endfunction

    // Present one transaction and hold it until the block accepts it. Valid is
    // only ever raised here and only lowered at the start of a gap or in
    // wait_quiet, so it never gets two nonblocking assignments in the same time step.
    task automatic push_access(input t_req rq);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rq.req_type;
        req_if.reg_index <= rq.reg_index;
        req_if.data_in   <= rq.data_in;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    // Send in bursts: when a burst runs out, insert a random gap and pick the
    // length of the next burst. Long bursts give back-to-back traffic.
    task automatic issue(input t_req rq);
        push_access(rq);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    // Hold the sender off until every expected result has been seen.
    task automatic wait_quiet();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    initial begin
        req_if.valid     <= 1'b0;
        req_if.req_type  <= REQ_READ;
        req_if.reg_index <= REG_DATA;
        req_if.data_in   <= 8'h00;
        i_rst_n          <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n          <= 1'b1;
        @(posedge i_clk);

        // Power-on values of line status and interrupt identification.
        issue(make_access(REQ_READ, REG_LSR, 8'h00));
        issue(make_access(REQ_READ, REG_IIR, 8'h00));
        issue(make_access(REQ_WRITE, REG_SCRATCH, 8'hff));
        issue(make_access(REQ_READ, REG_SCRATCH, 8'h00));
        // The unused request kind must leave everything alone.
        issue(make_access(REQ_UNUSED, 3'd7, 8'hff));
        // Divisor latch through DLAB, both bytes, then back to normal access.
        issue(make_access(REQ_WRITE, REG_LCR, 8'h80));
        issue(make_access(REQ_WRITE, REG_DATA, 8'hff));
        issue(make_access(REQ_WRITE, REG_IER, 8'h00));
        issue(make_access(REQ_READ, REG_DATA, 8'h00));
        issue(make_access(REQ_READ, REG_IER, 8'h00));
        issue(make_access(REQ_WRITE, REG_LCR, 8'h03));
        // Enabling the transmit interrupt with the transmitter empty raises it;
        // reading the identification clears it.
        issue(make_access(REQ_WRITE, REG_IER, 8'h0f));
        issue(make_access(REQ_READ, REG_IIR, 8'h00));
        // Two line bytes in a row cause an overrun, the top-priority interrupt.
        issue(make_access(REQ_RX, 3'd0, 8'h00));
        issue(make_access(REQ_RX, 3'd7, 8'hff));
        issue(make_access(REQ_READ, REG_IIR, 8'h00));
        issue(make_access(REQ_READ, REG_LSR, 8'h00));
        issue(make_access(REQ_READ, REG_DATA, 8'h00));
        // Loopback with all modem outputs set: modem deltas, looped transmit
        // bytes with overrun, and a line byte still taken in loopback.
        issue(make_access(REQ_WRITE, REG_MCR, 8'h1f));
        issue(make_access(REQ_READ, REG_MSR, 8'h00));
        issue(make_access(REQ_WRITE, REG_DATA, 8'h55));
        issue(make_access(REQ_WRITE, REG_DATA, 8'haa));
        issue(make_access(REQ_RX, 3'd0, 8'h3c));
        // Leaving loopback drops the ring indicator: trailing-edge delta.
        issue(make_access(REQ_WRITE, REG_MCR, 8'h00));
        // Writes to read-only offsets change nothing but still update the interrupt.
        issue(make_access(REQ_WRITE, REG_IIR, 8'hff));
        issue(make_access(REQ_WRITE, REG_LSR, 8'hff));
        issue(make_access(REQ_WRITE, REG_MSR, 8'hff));
        // Outside loopback a data write goes out to the line.
        issue(make_access(REQ_WRITE, REG_DATA, 8'ha5));
        issue(make_access(REQ_READ, REG_MSR, 8'h00));

        wait_quiet();

        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            issue(random_access());
            if (n == RANDOM_ACCESSES / 2)
                wait_quiet();
        end

        // Let every result come back, then give the block time to show any extra one.
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with the receiver in
    // its rarely-ready mode for every result.
    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/uartrm_pkg.sv
hw/rtl/uartrm_req_if.sv
hw/rtl/uartrm_rsp_if.sv
hw/rtl/uartrm_regs.sv
hw/rtl/uart_register_model_top.sv
tb/uartrm_checker.sv
tb/tb_uart_register_model_top.sv
